// ===== rtl/multi_voice_biquad_filter_unit_macros.svh =====
// Assertion macros used by the filter unit's controller.
`ifndef MULTI_VOICE_BIQUAD_FILTER_UNIT_MACROS_SVH
`define MULTI_VOICE_BIQUAD_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked on aclk, off while aresetn is low.
`define MVBQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while aresetn is low.
`define MVBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mvbq_pkg.sv =====
// Package: widths, codes, command struct and arithmetic helpers of the filter unit.
package mvbq_pkg;

    localparam int VOICES      = 9;
    localparam int VOICE_W     = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_W      = 24;
    localparam int COEF_FRAC   = 20;
    localparam int DELAY_W     = 32;
    localparam int REG_COUNT   = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = SAMPLE_BITS + COEF_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int RND_W       = ACC_W - COEF_FRAC;
    localparam int SUM_W       = DELAY_W + 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [DELAY_W-1:0]     delay_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic signed [RND_W-1:0]       rnd_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [VOICE_W-1:0]            voice_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

    // Coefficient register codes, also the configuration index
    typedef enum logic [CFG_IDX_W-1:0] {
        CS_FF0 = 3'd0,
        CS_FF1 = 3'd1,
        CS_FF2 = 3'd2,
        CS_FB1 = 3'd3,
        CS_FB2 = 3'd4
    } coef_sel_t;

    localparam coef_t COEF_RESET [REG_COUNT] = '{
        COEF_W'(1003), COEF_W'(2006), COEF_W'(1003), COEF_W'(-2029373), COEF_W'(985197)
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FF0,
        ST_OUT_Y,
        ST_MUL_FB1,
        ST_UPD_ONE,
        ST_WB
    } state_t;

    // Datapath commands issued by the controller each cycle
    typedef struct packed {
        logic      load;
        logic      pa_en;
        logic      pc_en;
        coef_sel_t ff_sel;
        logic      y_en;
        logic      pb_en;
        coef_sel_t fb_sel;
        logic      n1_en;
        logic      wb;
    } cmd_t;

    // Round half up and drop the coefficient fraction bits
    function automatic rnd_t rnd(input acc_t a);
        acc_t t;
        t = a + (acc_t'(1) <<< (COEF_FRAC - 1));
        return t[ACC_W-1:COEF_FRAC];
    endfunction

    // Saturate to the sample width
    function automatic sample_t sat_sample(input sum_t v);
        if ((&v[SUM_W-1:SAMPLE_BITS-1]) || !(|v[SUM_W-1:SAMPLE_BITS-1]))
            return v[SAMPLE_BITS-1:0];
        return {v[SUM_W-1], {(SAMPLE_BITS-1){~v[SUM_W-1]}}};
    endfunction

    // Saturate to the delay width
    function automatic delay_t sat_delay(input sum_t v);
        if ((&v[SUM_W-1:DELAY_W-1]) || !(|v[SUM_W-1:DELAY_W-1]))
            return v[DELAY_W-1:0];
        return {v[SUM_W-1], {(DELAY_W-1){~v[SUM_W-1]}}};
    endfunction

endpackage

// ===== rtl/multi_voice_biquad_filter_unit.sv =====
// Each input beat runs a five-step sequence around the two shared 24x24 multipliers
// (feed-forward products, then feedback products that need the finished output);
// a new input beat is taken only when the sequencer is back in idle.
// The result register frees the input side while a result beat waits to be taken.
// Reset (aresetn low, synchronous) loads the default coefficients and zeroes all
// voice delays; any in-range coefficient write zeroes all voice delays in the same cycle.
module multi_voice_biquad_filter_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mvbq_pkg::voice_t    s_voice,
    input  mvbq_pkg::sample_t   s_sample_in,
    output logic                m_valid,
    input  logic                m_ready,
    output mvbq_pkg::voice_t    m_voice_out,
    output mvbq_pkg::sample_t   m_sample_out,
    input  logic                cfg_we,
    input  mvbq_pkg::cfg_idx_t  cfg_index,
    input  mvbq_pkg::coef_t     cfg_wdata
);
    import mvbq_pkg::*;

    cmd_t cmd;

    // Sequencer
    mvbq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Arithmetic and state
    mvbq_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_voice      (s_voice),
        .s_sample_in  (s_sample_in),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .m_voice_out  (m_voice_out),
        .m_sample_out (m_sample_out)
    );

endmodule

// ===== rtl/mvbq_datapath.sv =====
// Datapath: coefficients, per-voice delays, two shared multipliers and result registers.
module mvbq_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mvbq_pkg::cmd_t           cmd,
    input  mvbq_pkg::voice_t         s_voice,
    input  mvbq_pkg::sample_t        s_sample_in,
    input  logic                     cfg_we,
    input  mvbq_pkg::cfg_idx_t       cfg_index,
    input  mvbq_pkg::coef_t          cfg_wdata,
    output mvbq_pkg::voice_t         m_voice_out,
    output mvbq_pkg::sample_t        m_sample_out
);
    import mvbq_pkg::*;

    coef_t   coef_reg [REG_COUNT];
    delay_t  delay_one_reg [VOICES];
    delay_t  delay_two_reg [VOICES];

    voice_t  v_reg;
    logic    v_ok_reg;
    sample_t x_reg;
    delay_t  s1_reg, s2_reg;
    prod_t   pa_reg, pb_reg, pc_reg;
    sample_t y_reg;
    delay_t  n1_reg;
    voice_t  m_voice_reg;
    sample_t m_sample_reg;

    logic    cfg_hit;
    logic    in_ok;
    prod_t   mul_a, mul_b;
    sample_t y_next;
    delay_t  n1_next, n2_next;

    assign cfg_hit = cfg_we && (cfg_index < cfg_idx_t'(REG_COUNT));
    assign in_ok   = s_voice < voice_t'(VOICES);

    // Shared multipliers: sample by feed-forward, output by feedback
    assign mul_a = prod_t'(x_reg) * prod_t'(coef_reg[cmd.ff_sel]);
    assign mul_b = prod_t'(y_reg) * prod_t'(coef_reg[cmd.fb_sel]);

    // Round, add delay where there is one, saturate
    assign y_next  = sat_sample(sum_t'(rnd(acc_t'(pa_reg))) + sum_t'(s1_reg));
    assign n1_next = sat_delay(sum_t'(rnd(acc_t'(pa_reg) - acc_t'(pb_reg))) + sum_t'(s2_reg));
    assign n2_next = sat_delay(sum_t'(rnd(acc_t'(pc_reg) - acc_t'(pb_reg))));

    // Coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) coef_reg[i] <= COEF_RESET[i];
        end else if (cfg_hit) begin
            coef_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Voice delay state: cleared on reset and on any in-range coefficient write
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            for (int i = 0; i < VOICES; i++) begin
                delay_one_reg[i] <= '0;
                delay_two_reg[i] <= '0;
            end
        end else if (cmd.wb && v_ok_reg) begin
            delay_one_reg[v_reg] <= n1_reg;
            delay_two_reg[v_reg] <= n2_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg    <= s_voice;
            v_ok_reg <= in_ok;
            x_reg    <= s_sample_in;
            s1_reg   <= in_ok ? delay_one_reg[s_voice] : '0;
            s2_reg   <= in_ok ? delay_two_reg[s_voice] : '0;
        end
        if (cmd.pa_en) pa_reg <= mul_a;
        if (cmd.pc_en) pc_reg <= mul_a;
        if (cmd.pb_en) pb_reg <= mul_b;
        if (cmd.y_en)  y_reg  <= y_next;
        if (cmd.n1_en) n1_reg <= n1_next;
        if (cmd.wb) begin
            m_voice_reg  <= v_reg;
            m_sample_reg <= y_reg;
        end
    end

    assign m_voice_out  = m_voice_reg;
    assign m_sample_out = m_sample_reg;

endmodule

// ===== rtl/mvbq_ctrl.sv =====
// Controller: sequencing state machine and result-beat handshake.
`include "multi_voice_biquad_filter_unit_macros.svh"

module mvbq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output mvbq_pkg::cmd_t  cmd
);
    import mvbq_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   slot_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (accept) state_next = ST_MUL_FF0;
            ST_MUL_FF0: state_next = ST_OUT_Y;
            ST_OUT_Y:   state_next = ST_MUL_FB1;
            ST_MUL_FB1: state_next = ST_UPD_ONE;
            ST_UPD_ONE: state_next = ST_WB;
            ST_WB:      if (slot_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd = '0;
        cmd.ff_sel = CS_FF0;
        cmd.fb_sel = CS_FB1;
        unique case (state_reg)
            ST_IDLE:    cmd.load = accept;
            ST_MUL_FF0: cmd.pa_en = 1'b1;
            ST_OUT_Y: begin
                cmd.y_en   = 1'b1;
                cmd.pa_en  = 1'b1;
                cmd.ff_sel = CS_FF1;
            end
            ST_MUL_FB1: begin
                cmd.pc_en  = 1'b1;
                cmd.ff_sel = CS_FF2;
                cmd.pb_en  = 1'b1;
                cmd.fb_sel = CS_FB1;
            end
            ST_UPD_ONE: begin
                cmd.n1_en  = 1'b1;
                cmd.pb_en  = 1'b1;
                cmd.fb_sel = CS_FB2;
            end
            ST_WB:      cmd.wb = slot_free;
            default:    cmd = '0;
        endcase
    end

    // Result beat valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.wb)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `MVBQ_ASSERT_NEXT(a_accept_starts, accept, state_reg == ST_MUL_FF0, "accept did not start")
    `MVBQ_ASSERT_NOW(a_wb_slot_free, cmd.wb, slot_free, "result overwrote a pending beat")
    `MVBQ_ASSERT_NEXT(a_wb_sets_valid, cmd.wb, m_valid_reg && state_reg == ST_IDLE, "wb lost")
    `MVBQ_ASSERT_NOW(a_load_idle_only, cmd.load, state_reg == ST_IDLE, "load outside idle")

endmodule
